@@ hdl/sorted_timeout_timer_queue_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Sorted timer queue assertion macros
// Immediate-antecedent and next-cycle property wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMEOUT_TIMER_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STTQ_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sttq: same-cycle check failed");

// next-cycle implication
`define STTQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sttq: next-cycle check failed");

`else

`define STTQ_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define STTQ_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/sttq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Field widths, command and result codes, transaction and chain op types.
// ----------------------------------------------------------------------------
`default_nettype none

package sttq_pkg;

    localparam int unsigned SLOTS_DEFAULT  = 32;
    localparam int unsigned SLOT_W_DEFAULT = $clog2(SLOTS_DEFAULT);
    localparam int unsigned CMD_W          = 3;
    localparam int unsigned ID_W           = 5;
    localparam int unsigned ID_EXT_W       = 7;   // holds any slot count up to 127
    localparam int unsigned CHAN_W         = 4;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned KIND_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_BIND  = 3'd2,
        CMD_START = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_GRANT   = 2'd0,
        KIND_NO_SLOT = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   timer_id;
        logic [CHAN_W-1:0] channel_id;
        logic [WORD_W-1:0] payload;
        logic [WORD_W-1:0] delay;
    } sttq_in_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   slot;
        logic [CHAN_W-1:0] dest_channel;
        logic [WORD_W-1:0] word;
        logic              last;
    } sttq_out_t;

    // one chain operation per cycle; none means holes keep walking
    typedef struct packed {
        logic ins;
        logic pop;
        logic del;
    } sttq_op_t;

endpackage

`default_nettype wire

@@ hdl/sttq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// One queue position: slot id and deadline, with sorted insert, shift-out
// and a walking hole used to close the gap left by a removal.
// ----------------------------------------------------------------------------
`default_nettype none

module sttq_cell #(
    parameter int unsigned SLOT_W = sttq_pkg::SLOT_W_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire sttq_pkg::sttq_op_t           op,
    input  wire logic [SLOT_W-1:0]            op_id,
    input  wire logic [sttq_pkg::WORD_W-1:0]  op_dl,
    input  wire logic                         left_keep,
    input  wire logic                         left_hole,
    input  wire logic                         left_valid,
    input  wire logic [SLOT_W-1:0]            left_id,
    input  wire logic [sttq_pkg::WORD_W-1:0]  left_dl,
    input  wire logic                         right_valid,
    input  wire logic [SLOT_W-1:0]            right_id,
    input  wire logic [sttq_pkg::WORD_W-1:0]  right_dl,
    output logic                              keep,
    output logic                              hole,
    output logic                              valid,
    output logic [SLOT_W-1:0]                 id,
    output logic [sttq_pkg::WORD_W-1:0]       dl
);
    import sttq_pkg::*;

    logic              valid_reg, valid_next;
    logic              hole_reg, hole_next;
    logic [SLOT_W-1:0] id_reg, id_next;
    logic [WORD_W-1:0] dl_reg, dl_next;

    // strictly earlier deadlines stay put; ties let the new timer go first
    assign keep  = valid_reg && (dl_reg < op_dl);
    assign hole  = hole_reg;
    assign valid = valid_reg;
    assign id    = id_reg;
    assign dl    = dl_reg;

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        dl_next    = dl_reg;
        hole_next  = 1'b0;
        if (op.pop) begin
            valid_next = right_valid;
            id_next    = right_id;
            dl_next    = right_dl;
        end else if (op.ins) begin
            if (!keep) begin
                if (left_keep) begin
                    valid_next = 1'b1;
                    id_next    = op_id;
                    dl_next    = op_dl;
                end else begin
                    valid_next = left_valid;
                    id_next    = left_id;
                    dl_next    = left_dl;
                end
            end
        end else if (op.del) begin
            if (valid_reg && (id_reg == op_id)) begin
                valid_next = 1'b0;
                hole_next  = 1'b1;
            end
        end else begin
            // hole moves one place toward the tail per cycle
            hole_next = left_hole;
            if (hole_reg) begin
                valid_next = right_valid;
                id_next    = right_id;
                dl_next    = right_dl;
            end else if (left_hole) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hole_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hole_reg  <= hole_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
        dl_reg <= dl_next;
    end

endmodule

`default_nettype wire

@@ hdl/sttq_chain.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue cell chain
// Row of queue cells, head at position zero, ascending deadline order.
// ----------------------------------------------------------------------------
`default_nettype none

module sttq_chain #(
    parameter int unsigned TIMER_SLOTS = sttq_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire sttq_pkg::sttq_op_t             op,
    input  wire logic [$clog2(TIMER_SLOTS)-1:0] op_id,
    input  wire logic [sttq_pkg::WORD_W-1:0]    op_dl,
    output logic                                head_valid,
    output logic [$clog2(TIMER_SLOTS)-1:0]      head_id,
    output logic [sttq_pkg::WORD_W-1:0]         head_dl
);
    import sttq_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TIMER_SLOTS);

    logic              keep_w  [TIMER_SLOTS];
    logic              hole_w  [TIMER_SLOTS];
    logic              valid_w [TIMER_SLOTS];
    logic [SLOT_W-1:0] id_w    [TIMER_SLOTS];
    logic [WORD_W-1:0] dl_w    [TIMER_SLOTS];

    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        logic              l_keep, l_hole, l_valid, r_valid;
        logic [SLOT_W-1:0] l_id, r_id;
        logic [WORD_W-1:0] l_dl, r_dl;

        if (i == 0) begin : g_head
            assign l_keep  = 1'b1;
            assign l_hole  = 1'b0;
            assign l_valid = 1'b0;
            assign l_id    = '0;
            assign l_dl    = '0;
        end else begin : g_body
            assign l_keep  = keep_w[i-1];
            assign l_hole  = hole_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_id    = id_w[i-1];
            assign l_dl    = dl_w[i-1];
        end

        if (i == TIMER_SLOTS - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_id    = '0;
            assign r_dl    = '0;
        end else begin : g_inner
            assign r_valid = valid_w[i+1];
            assign r_id    = id_w[i+1];
            assign r_dl    = dl_w[i+1];
        end

        sttq_cell #(
            .SLOT_W(SLOT_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .op_id      (op_id),
            .op_dl      (op_dl),
            .left_keep  (l_keep),
            .left_hole  (l_hole),
            .left_valid (l_valid),
            .left_id    (l_id),
            .left_dl    (l_dl),
            .right_valid(r_valid),
            .right_id   (r_id),
            .right_dl   (r_dl),
            .keep       (keep_w[i]),
            .hole       (hole_w[i]),
            .valid      (valid_w[i]),
            .id         (id_w[i]),
            .dl         (dl_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_id    = id_w[0];
    assign head_dl    = dl_w[0];

endmodule

`default_nettype wire

@@ hdl/sorted_timeout_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Sorted timeout timer queue unit
// A pool of TIMER_SLOTS software timers held in deadline order in a row of
// cells. One command transaction is taken at a time: bind and start complete
// without leaving idle; allocate scans the slot flags one slot per cycle up to
// the first free slot or the last slot; freeing a running timer leaves a hole
// that walks one cell per cycle to the tail while the unit waits in a settle
// state; a tick compares the head cell and, while it is due, shifts it out
// and reports it, one expired timer after another. Result transactions wait
// in an output register, so a back-pressured result delays only the next
// command that produces one. Deadlines are delay + tick count modulo 2^32 and
// compare unsigned. Reset clears control state, slot flags and cell valid
// flags, not stored ids and deadlines; the bound channel and data word of a
// slot read as garbage until first bound.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_timeout_timer_queue_unit_macros.svh"

module sorted_timeout_timer_queue_unit #(
    parameter int unsigned TIMER_SLOTS = sttq_pkg::SLOTS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sttq_pkg::sttq_in_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sttq_pkg::sttq_out_t      m_item
);
    import sttq_pkg::*;

    localparam int unsigned SLOT_W = $clog2(TIMER_SLOTS);
    localparam int unsigned CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam logic [ID_EXT_W-1:0] SLOTS_EXT  = ID_EXT_W'(TIMER_SLOTS);
    localparam logic [SLOT_W-1:0]   LAST_SLOT  = SLOT_W'(TIMER_SLOTS - 1);
    localparam logic [CNT_W-1:0]    SETTLE_LEN = CNT_W'(TIMER_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SCAN      = 5'b00010,
        ST_SETTLE    = 5'b00100,
        ST_POP_CHECK = 5'b01000,
        ST_POP_LOAD  = 5'b10000
    } state_t;

    // slot index to result slot field
    function automatic logic [ID_W-1:0] to_slot(input logic [SLOT_W-1:0] s);
        logic [ID_EXT_W-1:0] e;
        e = ID_EXT_W'(s);
        return e[ID_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [WORD_W-1:0]  tick_reg, tick_next;
    logic [TIMER_SLOTS-1:0] used_reg, used_next;   // allocated or running
    logic [TIMER_SLOTS-1:0] run_reg, run_next;     // running (in the chain)
    logic [SLOT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]   settle_reg, settle_next;
    logic [SLOT_W-1:0]  pop_slot_reg, pop_slot_next;
    logic               m_valid_reg, m_valid_next;
    sttq_out_t          m_item_reg, m_item_next;

    // bound channel and word per slot
    logic [CHAN_W+WORD_W-1:0] bound_mem [TIMER_SLOTS];
    logic [CHAN_W+WORD_W-1:0] bound_rd_reg;

    logic                s_fire;
    logic [ID_EXT_W-1:0] id_ext;
    logic                id_ok;
    logic [SLOT_W-1:0]   id_idx;
    logic                out_free;
    logic [WORD_W-1:0]   start_dl;
    logic                bind_we;
    logic                rd_en;

    sttq_op_t            op;
    logic                head_valid;
    logic [SLOT_W-1:0]   head_id;
    logic [WORD_W-1:0]   head_dl;
    logic                head_due;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign id_ext   = ID_EXT_W'(s_item.timer_id);
    assign id_ok    = (id_ext < SLOTS_EXT);
    assign id_idx   = id_ext[SLOT_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign start_dl = s_item.delay + tick_reg;
    assign head_due = head_valid && (head_dl <= tick_reg);
    assign bind_we  = s_fire && (s_item.cmd == CMD_BIND) && id_ok;
    assign rd_en    = (state_reg == ST_POP_CHECK) && head_due;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    sttq_chain #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .op_id     (id_idx),
        .op_dl     (start_dl),
        .head_valid(head_valid),
        .head_id   (head_id),
        .head_dl   (head_dl)
    );

    always_comb begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        used_next     = used_reg;
        run_next      = run_reg;
        scan_next     = scan_reg;
        settle_next   = settle_reg;
        pop_slot_next = pop_slot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        op            = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_item.cmd)
                        CMD_ALLOC: begin
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_FREE: begin
                            if (id_ok) begin
                                used_next[id_idx] = 1'b0;
                                run_next[id_idx]  = 1'b0;
                                if (run_reg[id_idx]) begin
                                    op.del      = 1'b1;
                                    settle_next = SETTLE_LEN;
                                    state_next  = ST_SETTLE;
                                end
                            end
                        end
                        CMD_START: begin
                            if (id_ok && used_reg[id_idx] && !run_reg[id_idx]) begin
                                op.ins           = 1'b1;
                                run_next[id_idx] = 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            tick_next  = tick_reg + 1'b1;
                            state_next = ST_POP_CHECK;
                        end
                        default: begin
                            // bind goes straight to the memory; unknown codes drop
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (!used_reg[scan_reg] || (scan_reg == LAST_SLOT)) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_item_next  = '0;
                        m_item_next.last = 1'b1;
                        if (!used_reg[scan_reg]) begin
                            used_next[scan_reg] = 1'b1;
                            m_item_next.kind    = KIND_GRANT;
                            m_item_next.slot    = to_slot(scan_reg);
                        end else begin
                            m_item_next.kind    = KIND_NO_SLOT;
                        end
                        state_next = ST_IDLE;
                    end
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_SETTLE: begin
                if (settle_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    settle_next = settle_reg - 1'b1;
                end
            end

            ST_POP_CHECK: begin
                if (head_due) begin
                    op.pop            = 1'b1;
                    pop_slot_next     = head_id;
                    run_next[head_id] = 1'b0;
                    state_next        = ST_POP_LOAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_POP_LOAD: begin
                // chain already shifted: head_due now speaks for the next timer
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_item_next.kind         = KIND_EXPIRED;
                    m_item_next.slot         = to_slot(pop_slot_reg);
                    m_item_next.dest_channel = bound_rd_reg[CHAN_W+WORD_W-1:WORD_W];
                    m_item_next.word         = bound_rd_reg[WORD_W-1:0];
                    m_item_next.last         = !head_due;
                    state_next               = head_due ? ST_POP_CHECK : ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            used_reg     <= '0;
            run_reg      <= '0;
            scan_reg     <= '0;
            settle_reg   <= '0;
            pop_slot_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            used_reg     <= used_next;
            run_reg      <= run_next;
            scan_reg     <= scan_next;
            settle_reg   <= settle_next;
            pop_slot_reg <= pop_slot_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    // binding memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (bind_we) begin
            bound_mem[id_idx] <= {s_item.channel_id, s_item.payload};
        end
        if (rd_en) begin
            bound_rd_reg <= bound_mem[head_id];
        end
    end

    // a running timer is always also allocated
    `STTQ_ASSERT_IMPL(a_run_implies_used, aclk, aresetn, 1'b1, (run_reg & ~used_reg) == '0)
    // whatever heads the chain between commands is a running timer
    `STTQ_ASSERT_IMPL(a_head_running, aclk, aresetn,
                      (state_reg == ST_IDLE) && head_valid, run_reg[head_id])
    // an expired timer goes back to allocated before it is reported
    `STTQ_ASSERT_IMPL(a_popped_alloc, aclk, aresetn, state_reg == ST_POP_LOAD,
                      used_reg[pop_slot_reg] && !run_reg[pop_slot_reg])
    // a legal start marks the slot running
    `STTQ_ASSERT_NEXT(a_start_runs, aclk, aresetn,
                      s_fire && (s_item.cmd == CMD_START) && id_ok
                          && used_reg[id_idx] && !run_reg[id_idx],
                      run_reg[$past(id_idx)])

endmodule

`default_nettype wire
